// ===== design/lsr_pkg.sv =====
// lsr_pkg: shared types and constants of the line segment rasterizer
// command and status words between controller and datapath, register map
// no dependencies
package lsr_pkg;

    localparam int CANVAS_W = 7;
    localparam logic [CANVAS_W-1:0] CANVAS_RESET = 7'd64;

    localparam int APB_DATA_W = 32;
    localparam int PADDR_W = 3;
    localparam int REG_IDX_W = 1;
    localparam logic [REG_IDX_W-1:0] REG_CANVAS_SIZE = 1'b0;

    typedef struct packed {
        logic load;
        logic setup;
        logic step;
    } lsr_cmd_t;

    typedef struct packed {
        logic degenerate;
        logic fin;
        logic out_free;
    } lsr_sts_t;

endpackage

// ===== design/lsr_if.sv =====
// lsr_seg_if and lsr_pix_if: valid/ready channels of the rasterizer
// segment words in, pixel words out; no dependencies
interface lsr_seg_if #(parameter int COORD_BITS = 6);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] start_x;
    logic [COORD_BITS-1:0] start_y;
    logic [COORD_BITS-1:0] end_x;
    logic [COORD_BITS-1:0] end_y;

    modport source (output valid, output start_x, output start_y, output end_x,
                    output end_y, input ready);
    modport sink (input valid, input start_x, input start_y, input end_x,
                  input end_y, output ready);
endinterface

interface lsr_pix_if #(parameter int COORD_BITS = 6);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic                  visible;
    logic                  last;

    modport source (output valid, output pixel_x, output pixel_y, output visible,
                    output last, input ready);
    modport sink (input valid, input pixel_x, input pixel_y, input visible,
                  input last, output ready);
endinterface

// ===== design/lsr_ctrl.sv =====
// lsr_ctrl: sequencer of the rasterizer, one segment at a time
// depends on lsr_pkg
module lsr_ctrl
    import lsr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  lsr_sts_t sts,
    output lsr_cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SETUP = 3'b010,
        ST_RUN   = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                cmd.setup = 1'b1;
                state_next = sts.degenerate ? ST_IDLE : ST_RUN;
            end
            ST_RUN:
            begin
                if (sts.out_free)
                begin
                    cmd.step = 1'b1;
                    if (sts.fin)
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    a_step_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> sts.out_free)
        else $error("pixel step while output word is held");

    a_fin_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.step && sts.fin) |=> (state_reg == ST_IDLE))
        else $error("segment did not end on final pixel");

    a_no_step_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !(cmd.step || cmd.setup))
        else $error("datapath busy while taking a new segment");

endmodule

// ===== design/lsr_datapath.sv =====
// lsr_datapath: segment setup, Bresenham stepping and output word register
// depends on lsr_pkg; driven by lsr_ctrl
module lsr_datapath
    import lsr_pkg::*;
#(
    parameter int COORD_BITS = 6
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  lsr_cmd_t              cmd,
    output lsr_sts_t              sts,
    input  logic [COORD_BITS-1:0] start_x,
    input  logic [COORD_BITS-1:0] start_y,
    input  logic [COORD_BITS-1:0] end_x,
    input  logic [COORD_BITS-1:0] end_y,
    input  logic [CANVAS_W-1:0]   canvas_size,
    input  logic                  out_ready,
    output logic                  out_valid,
    output logic [COORD_BITS-1:0] pixel_x,
    output logic [COORD_BITS-1:0] pixel_y,
    output logic                  visible,
    output logic                  last
);

    localparam int ERR_W = COORD_BITS + 2;
    localparam int VIS_W = (COORD_BITS > CANVAS_W) ? COORD_BITS : CANVAS_W;

    logic [COORD_BITS-1:0] sx_reg, sy_reg, ex_reg, ey_reg;
    logic [COORD_BITS-1:0] sx_next, sy_next, ex_next, ey_next;
    logic [COORD_BITS-1:0] cur_major_reg, cur_major_next;
    logic [COORD_BITS-1:0] cur_minor_reg, cur_minor_next;
    logic [COORD_BITS-1:0] end_major_reg, end_major_next;
    logic [COORD_BITS-1:0] dmaj_reg, dmaj_next;
    logic [COORD_BITS-1:0] dmin_reg, dmin_next;
    logic signed [ERR_W-1:0] err_reg, err_next;
    logic y_major_reg, y_major_next;
    logic minor_down_reg, minor_down_next;
    logic axis_reg, axis_next;
    logic out_valid_reg, out_valid_next;
    logic [COORD_BITS-1:0] pix_x_reg, pix_x_next;
    logic [COORD_BITS-1:0] pix_y_reg, pix_y_next;
    logic visible_reg, visible_next;
    logic last_reg, last_next;

    logic [COORD_BITS-1:0] dx, dy, ma0, ma1, mi0, mi1, px, py;
    logic                  y_major, fin;
    logic signed [ERR_W-1:0] dmaj_ext, dmin_ext, err_step;

    // setup from the stored endpoints
    always_comb
    begin
        dx = (sx_reg > ex_reg) ? sx_reg - ex_reg : ex_reg - sx_reg;
        dy = (sy_reg > ey_reg) ? sy_reg - ey_reg : ey_reg - sy_reg;
        y_major = (dx <= dy);
        if (y_major)
        begin
            if (sy_reg <= ey_reg)
            begin
                ma0 = sy_reg; ma1 = ey_reg; mi0 = sx_reg; mi1 = ex_reg;
            end
            else
            begin
                ma0 = ey_reg; ma1 = sy_reg; mi0 = ex_reg; mi1 = sx_reg;
            end
        end
        else
        begin
            if (sx_reg <= ex_reg)
            begin
                ma0 = sx_reg; ma1 = ex_reg; mi0 = sy_reg; mi1 = ey_reg;
            end
            else
            begin
                ma0 = ex_reg; ma1 = sx_reg; mi0 = ey_reg; mi1 = sy_reg;
            end
        end
    end

    // current pixel and error update
    always_comb
    begin
        px = y_major_reg ? cur_minor_reg : cur_major_reg;
        py = y_major_reg ? cur_major_reg : cur_minor_reg;
        if (axis_reg)
            fin = ({1'b0, cur_major_reg} + 1'b1) == {1'b0, end_major_reg};
        else
            fin = (cur_major_reg == end_major_reg);
        dmaj_ext = $signed({{(ERR_W-COORD_BITS){1'b0}}, dmaj_reg});
        dmin_ext = $signed({{(ERR_W-COORD_BITS){1'b0}}, dmin_reg});
        if (!err_reg[ERR_W-1])
            err_step = err_reg - dmaj_ext + dmin_ext;
        else
            err_step = err_reg + dmin_ext;
    end

    always_comb
    begin
        sx_next         = sx_reg;
        sy_next         = sy_reg;
        ex_next         = ex_reg;
        ey_next         = ey_reg;
        cur_major_next  = cur_major_reg;
        cur_minor_next  = cur_minor_reg;
        end_major_next  = end_major_reg;
        dmaj_next       = dmaj_reg;
        dmin_next       = dmin_reg;
        err_next        = err_reg;
        y_major_next    = y_major_reg;
        minor_down_next = minor_down_reg;
        axis_next       = axis_reg;
        pix_x_next      = pix_x_reg;
        pix_y_next      = pix_y_reg;
        visible_next    = visible_reg;
        last_next       = last_reg;
        out_valid_next  = out_ready ? 1'b0 : out_valid_reg;

        if (cmd.load)
        begin
            sx_next = start_x;
            sy_next = start_y;
            ex_next = end_x;
            ey_next = end_y;
        end

        if (cmd.setup)
        begin
            cur_major_next  = ma0;
            cur_minor_next  = mi0;
            end_major_next  = ma1;
            dmaj_next       = y_major ? dy : dx;
            dmin_next       = y_major ? dx : dy;
            y_major_next    = y_major;
            minor_down_next = (mi1 < mi0);
            axis_next       = y_major ? (dx == '0) : (dy == '0);
            err_next        = $signed({{(ERR_W-COORD_BITS){1'b0}}, y_major ? dx : dy})
                            - $signed({{(ERR_W-COORD_BITS){1'b0}}, y_major ? dy : dx});
        end

        if (cmd.step)
        begin
            out_valid_next = 1'b1;
            pix_x_next     = px;
            pix_y_next     = py;
            visible_next   = (VIS_W'(px) < VIS_W'(canvas_size))
                          && (VIS_W'(py) < VIS_W'(canvas_size));
            last_next      = fin;
            cur_major_next = cur_major_reg + 1'b1;
            if (!axis_reg)
            begin
                err_next = err_step;
                if (!err_reg[ERR_W-1])
                    cur_minor_next = minor_down_reg ? cur_minor_reg - 1'b1
                                                    : cur_minor_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        sx_reg         <= sx_next;
        sy_reg         <= sy_next;
        ex_reg         <= ex_next;
        ey_reg         <= ey_next;
        cur_major_reg  <= cur_major_next;
        cur_minor_reg  <= cur_minor_next;
        end_major_reg  <= end_major_next;
        dmaj_reg       <= dmaj_next;
        dmin_reg       <= dmin_next;
        err_reg        <= err_next;
        y_major_reg    <= y_major_next;
        minor_down_reg <= minor_down_next;
        axis_reg       <= axis_next;
        pix_x_reg      <= pix_x_next;
        pix_y_reg      <= pix_y_next;
        visible_reg    <= visible_next;
        last_reg       <= last_next;
    end

    assign sts.degenerate = (sx_reg == ex_reg) && (sy_reg == ey_reg);
    assign sts.fin        = fin;
    assign sts.out_free   = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign pixel_x   = pix_x_reg;
    assign pixel_y   = pix_y_reg;
    assign visible   = visible_reg;
    assign last      = last_reg;

    a_sloped_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.step && !axis_reg) |-> (cur_major_reg <= end_major_reg))
        else $error("sloped segment stepped past far endpoint");

    a_axis_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.step && axis_reg) |-> (cur_major_reg < end_major_reg))
        else $error("axis aligned segment reached its excluded endpoint");

    a_word_released: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_ready && !cmd.step) |=> !out_valid_reg)
        else $error("taken pixel word shown again");

endmodule

// ===== design/line_segment_rasterizer.sv =====
// line_segment_rasterizer: top level, canvas size register and APB port
// depends on lsr_pkg, lsr_if, lsr_ctrl, lsr_datapath
//
// usage: a segment word (start_x, start_y, end_x, end_y) enters on the
// segment channel; the block emits its pixel words on the pixel channel,
// each with pixel_x, pixel_y, a visible flag against the canvas and last
// on the final pixel. a segment with equal endpoints emits nothing.
// timing: the segment is taken in the idle state, a setup state follows,
// then one pixel is stepped per cycle into the output word register while
// that register is free or being taken; a segment has at most
// 2^COORD_BITS pixels. the pace is set by the single shared stepping unit
// of the datapath. a stalled receiver holds the pixel word and the stepper
// waits; a new segment may be taken while the last pixel word still waits.
// reset: idle, no word pending, canvas_size 64. canvas_size is written over
// APB at byte address 0; the user must write it only while no segment is in
// progress, as the block itself does not enforce it.
module line_segment_rasterizer
    import lsr_pkg::*;
#(
    parameter int COORD_BITS = 6
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    lsr_seg_if.sink               segment,
    lsr_pix_if.source             pixel,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_W-1:0]    paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [CANVAS_W-1:0] canvas_reg;
    logic [CANVAS_W-1:0] canvas_next;
    logic                reg_hit;
    lsr_cmd_t            cmd;
    lsr_sts_t            sts;

    assign reg_hit = (paddr[PADDR_W-1:2] == REG_CANVAS_SIZE);
    assign pready  = 1'b1;
    assign prdata  = reg_hit ? APB_DATA_W'(canvas_reg) : '0;

    always_comb
    begin
        canvas_next = canvas_reg;
        if (psel && penable && pwrite && reg_hit)
            canvas_next = pwdata[CANVAS_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            canvas_reg <= CANVAS_RESET;
        else
            canvas_reg <= canvas_next;
    end

    lsr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (segment.valid),
        .in_ready (segment.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    lsr_datapath #(
        .COORD_BITS (COORD_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .start_x     (segment.start_x),
        .start_y     (segment.start_y),
        .end_x       (segment.end_x),
        .end_y       (segment.end_y),
        .canvas_size (canvas_reg),
        .out_ready   (pixel.ready),
        .out_valid   (pixel.valid),
        .pixel_x     (pixel.pixel_x),
        .pixel_y     (pixel.pixel_y),
        .visible     (pixel.visible),
        .last        (pixel.last)
    );

endmodule

// ===== verif/tb_top.sv =====
// tb_top: self-checking testbench of line_segment_rasterizer
// drives segment words and canvas_size writes, checks every pixel word
// against a scoreboard; depends on lsr_pkg, lsr_if and the design
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import lsr_pkg::*;

    localparam int COORD_BITS = 6;
    localparam int COORD_MAX = (1 << COORD_BITS) - 1;
    localparam logic [REG_IDX_W-1:0] REG_SPARE = 1'b1;
    localparam logic [PADDR_W-1:0] ADDR_CANVAS = {REG_CANVAS_SIZE, 2'b00};
    localparam logic [PADDR_W-1:0] ADDR_SPARE = {REG_SPARE, 2'b00};
    localparam int SETTLE_CYCLES = 10;
    localparam int DRAIN_CYCLES = (1 << COORD_BITS) + 8;
    localparam int SEGMENTS_PER_PHASE = 50;
    localparam int HOLD_CYCLES = 400;
    localparam int LIMIT_NS = 5_000_000;

    typedef logic [COORD_BITS-1:0] coord_t;

    typedef struct packed {
        coord_t pixel_x;
        coord_t pixel_y;
        logic   visible;
        logic   last;
    } pixel_t;

    class pixel_scoreboard;
        logic [CANVAS_W-1:0] canvas;
        pixel_t expected_pixels[$];
        int errors;

        function new();
            canvas = CANVAS_RESET;
            errors = 0;
        endfunction

        function int pending();
            return expected_pixels.size();
        endfunction

        function void emit(bit y_major, int major, int minor, bit fin);
            pixel_t p;
            int px;
            int py;
            px = y_major ? minor : major;
            py = y_major ? major : minor;
            p.pixel_x = coord_t'(px);
            p.pixel_y = coord_t'(py);
            p.visible = (px < int'(canvas)) && (py < int'(canvas));
            p.last = fin;
            expected_pixels = {expected_pixels, p};
        endfunction

        // stepped pixels of one segment, major coordinate increasing
        function void add_segment(coord_t sx, coord_t sy, coord_t ex, coord_t ey);
            int dx;
            int dy;
            int ma0;
            int ma1;
            int mi0;
            int mi1;
            int dmaj;
            int dmin;
            int cur;
            int minor;
            int err;
            bit y_major;
            bit minor_down;
            bit fin;
            dx = (sx > ex) ? int'(sx) - int'(ex) : int'(ex) - int'(sx);
            dy = (sy > ey) ? int'(sy) - int'(ey) : int'(ey) - int'(sy);
            if (dx == 0 && dy == 0)
                return;
            y_major = (dx <= dy);
            if (y_major)
            begin
                if (sy <= ey)
                begin
                    ma0 = sy; ma1 = ey; mi0 = sx; mi1 = ex;
                end
                else
                begin
                    ma0 = ey; ma1 = sy; mi0 = ex; mi1 = sx;
                end
                dmaj = dy;
                dmin = dx;
            end
            else
            begin
                if (sx <= ex)
                begin
                    ma0 = sx; ma1 = ex; mi0 = sy; mi1 = ey;
                end
                else
                begin
                    ma0 = ex; ma1 = sx; mi0 = ey; mi1 = sy;
                end
                dmaj = dx;
                dmin = dy;
            end
            minor_down = (mi1 < mi0);
            minor = mi0;
            if (dmin == 0)
            begin
                // axis aligned: far endpoint left out
                for (cur = ma0; cur < ma1; cur++)
                    emit(y_major, cur, minor, cur + 1 == ma1);
            end
            else
            begin
                err = dmin - dmaj;
                cur = ma0;
                forever
                begin
                    fin = (cur == ma1);
                    emit(y_major, cur, minor, fin);
                    if (err >= 0)
                    begin
                        minor = minor_down ? ((minor - 1) & COORD_MAX)
                                           : ((minor + 1) & COORD_MAX);
                        err -= dmaj;
                    end
                    err += dmin;
                    if (fin)
                        break;
                    cur++;
                end
            end
        endfunction

        function void check_pixel(pixel_t got);
            pixel_t exp_pix;
            if (expected_pixels.size() == 0)
            begin
                $error("unexpected pixel word: pixel_x=%0d pixel_y=%0d",
                       got.pixel_x, got.pixel_y);
                errors++;
                return;
            end
            exp_pix = expected_pixels.pop_front();
            if (got.pixel_x !== exp_pix.pixel_x)
            begin
                $error("pixel_x: expected %0d, got %0d", exp_pix.pixel_x, got.pixel_x);
                errors++;
            end
            if (got.pixel_y !== exp_pix.pixel_y)
            begin
                $error("pixel_y: expected %0d, got %0d", exp_pix.pixel_y, got.pixel_y);
                errors++;
            end
            if (got.visible !== exp_pix.visible)
            begin
                $error("visible: expected %0d, got %0d", exp_pix.visible, got.visible);
                errors++;
            end
            if (got.last !== exp_pix.last)
            begin
                $error("last: expected %0d, got %0d", exp_pix.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [PADDR_W-1:0]    paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    bit seg_burst = 1'b0;
    bit pix_burst = 1'b0;
    bit hold_off = 1'b0;

    pixel_scoreboard sb = new();

    lsr_seg_if #(.COORD_BITS(COORD_BITS)) seg_bus ();
    lsr_pix_if #(.COORD_BITS(COORD_BITS)) pix_bus ();

    line_segment_rasterizer #(.COORD_BITS(COORD_BITS)) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .segment (seg_bus),
        .pixel   (pix_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #LIMIT_NS;
        $display("** line_segment_rasterizer: FAILED **");
        $finish;
    end

    task automatic apb_write(input logic [PADDR_W-1:0] addr,
                             input logic [APB_DATA_W-1:0] data);
        @(negedge clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = addr;
        pwdata = data;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic apb_read(input logic [PADDR_W-1:0] addr,
                            output logic [APB_DATA_W-1:0] data);
        @(negedge clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = addr;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        data = prdata;
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
    endtask

    task automatic check_canvas_reg();
        logic [APB_DATA_W-1:0] rd;
        apb_read(ADDR_CANVAS, rd);
        if (rd[CANVAS_W-1:0] !== sb.canvas)
        begin
            $error("canvas_size: expected %0d, got %0d", sb.canvas, rd[CANVAS_W-1:0]);
            sb.errors++;
        end
    endtask

    task automatic write_canvas(input logic [APB_DATA_W-1:0] value);
        apb_write(ADDR_CANVAS, value);
        sb.canvas = value[CANVAS_W-1:0];
        check_canvas_reg();
    endtask

    task automatic send_segment(input coord_t sx, input coord_t sy,
                                input coord_t ex, input coord_t ey);
        int gap;
        if ($urandom_range(0, 15) == 0)
            seg_burst = !seg_burst;
        gap = seg_burst ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            @(negedge clk);
            seg_bus.valid = 1'b0;
            for (int i = 1; i < gap; i++)
                @(negedge clk);
        end
        @(negedge clk);
        seg_bus.valid = 1'b1;
        seg_bus.start_x = sx;
        seg_bus.start_y = sy;
        seg_bus.end_x = ex;
        seg_bus.end_y = ey;
        do @(posedge clk); while (!seg_bus.ready);
        sb.add_segment(sx, sy, ex, ey);
    endtask

    function automatic coord_t near_coord(coord_t base);
        int c;
        c = int'(base) + $urandom_range(0, 14) - 7;
        if (c < 0)
            c = 0;
        if (c > COORD_MAX)
            c = COORD_MAX;
        return coord_t'(c);
    endfunction

    // mostly short segments, some full range, axis aligned, diagonal, point
    task automatic send_random_segments(input int count);
        coord_t sx;
        coord_t sy;
        coord_t ex;
        coord_t ey;
        coord_t t;
        int d;
        repeat (count)
        begin
            sx = coord_t'($urandom_range(0, COORD_MAX));
            sy = coord_t'($urandom_range(0, COORD_MAX));
            ex = coord_t'($urandom_range(0, COORD_MAX));
            ey = coord_t'($urandom_range(0, COORD_MAX));
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4:
                begin
                    ex = near_coord(sx);
                    ey = near_coord(sy);
                end
                5, 6: ;
                7:
                begin
                    if ($urandom_range(0, 1))
                        ey = sy;
                    else
                        ex = sx;
                end
                8:
                begin
                    d = $urandom_range(1, COORD_MAX);
                    sx = coord_t'($urandom_range(0, COORD_MAX - d));
                    sy = coord_t'($urandom_range(0, COORD_MAX - d));
                    ex = coord_t'(int'(sx) + d);
                    ey = coord_t'(int'(sy) + d);
                    if ($urandom_range(0, 1))
                    begin
                        t = sx;
                        sx = ex;
                        ex = t;
                    end
                end
                default:
                begin
                    ex = sx;
                    ey = sy;
                end
            endcase
            send_segment(sx, sy, ex, ey);
        end
    endtask

    task automatic drain();
        @(negedge clk);
        seg_bus.valid = 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // pixel receiver with random stalls and the long hold-off
    initial
    begin
        int stall;
        pix_bus.ready = 1'b1;
        forever
        begin
            if ($urandom_range(0, 15) == 0)
                pix_burst = !pix_burst;
            stall = pix_burst ? 0 : $urandom_range(0, 4);
            if (stall > 0 || hold_off)
            begin
                @(negedge clk);
                pix_bus.ready = 1'b0;
                for (int i = 1; i < stall; i++)
                    @(negedge clk);
                while (hold_off)
                    @(negedge clk);
                @(negedge clk);
                pix_bus.ready = 1'b1;
            end
            do @(posedge clk); while (!pix_bus.valid);
            sb.check_pixel('{pixel_x: pix_bus.pixel_x, pixel_y: pix_bus.pixel_y,
                             visible: pix_bus.visible, last: pix_bus.last});
        end
    end

    initial
    begin
        logic [CANVAS_W-1:0] canvas_values[6];
        logic [APB_DATA_W-1:0] value;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        seg_bus.valid = 1'b0;
        seg_bus.start_x = '0;
        seg_bus.start_y = '0;
        seg_bus.end_x = '0;
        seg_bus.end_y = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        check_canvas_reg();

        // diagonals, both axis aligned directions, points, shallow and steep
        send_segment(0, 0, 63, 63);
        send_segment(63, 0, 0, 63);
        send_segment(0, 0, 63, 0);
        send_segment(63, 63, 0, 63);
        send_segment(5, 63, 5, 0);
        send_segment(0, 0, 0, 63);
        send_segment(0, 5, 0, 5);
        send_segment(63, 63, 63, 63);
        send_segment(0, 0, 63, 1);
        send_segment(63, 63, 0, 62);
        send_segment(10, 10, 12, 30);
        send_segment(30, 12, 10, 10);
        send_segment(1, 0, 0, 0);
        send_segment(0, 0, 0, 1);
        send_segment(0, 0, 1, 1);
        send_segment(2, 7, 9, 3);
        send_segment(40, 20, 20, 60);
        send_segment(63, 0, 0, 1);
        drain();

        // write to an unmapped register leaves canvas_size alone
        apb_write(ADDR_SPARE, 32'd5);
        check_canvas_reg();

        canvas_values = '{7'd0, 7'd1, 7'd127, 7'd33,
                          7'($urandom_range(2, 63)), 7'd64};
        foreach (canvas_values[p])
        begin
            value = ($urandom() & ~32'h7F) | APB_DATA_W'(canvas_values[p]);
            write_canvas(value);
            if (p == 1)
            begin
                send_random_segments(10);
                fork
                    begin
                        @(negedge clk);
                        hold_off = 1'b1;
                        repeat (HOLD_CYCLES) @(negedge clk);
                        hold_off = 1'b0;
                    end
                join_none
                send_random_segments(SEGMENTS_PER_PHASE - 10);
            end
            else
                send_random_segments(SEGMENTS_PER_PHASE);
            drain();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("** line_segment_rasterizer: PASSED **");
        else
            $display("** line_segment_rasterizer: FAILED **");
        $finish;
    end

endmodule
